>>> rtl/skt_pkg.sv
// shared types and constants for the sorted key table
package skt_pkg;

    localparam int KEY_IN_W    = 48;
    localparam int HANDLE_W    = 16;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 7;
    localparam int S_TDATA_W   = 64;
    localparam int M_TDATA_W   = 16;

    typedef enum logic
    {
        FN_INSERT = 1'b0,
        FN_DELETE = 1'b1
    } func_t;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_DONE     = 2'd0,
        ST_DUP      = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    // controller to datapath
    typedef struct packed
    {
        logic load;   // capture the incoming item
        logic exec;   // apply the operation and post the result
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed
    {
        logic out_busy;   // result register holds an item not taken this cycle
    } dp_sts_t;

endpackage

>>> rtl/skt_ctrl.sv
// controller state machine for the sorted key table
module skt_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  skt_pkg::dp_sts_t  sts,
    output skt_pkg::ctrl_cmd_t cmd
);
    import skt_pkg::*;

    typedef enum logic [1:0]
    {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // wait for room in the result register
                if (!sts.out_busy)
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/skt_datapath.sv
// row of key cells with compare, shift and result register
module skt_datapath #(
    parameter int DEPTH = 64,
    parameter int KW    = 48
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  skt_pkg::ctrl_cmd_t             cmd,
    output skt_pkg::dp_sts_t               sts,
    input  logic [skt_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [skt_pkg::M_TDATA_W-1:0]  m_tdata
);
    import skt_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    // captured item
    func_t                func_reg;
    logic [KW-1:0]        key_in_reg;
    logic [HANDLE_W-1:0]  handle_in_reg;

    // cells
    logic [KW-1:0]        key_reg     [DEPTH];
    logic [HANDLE_W-1:0]  handle_reg  [DEPTH];
    logic [KW-1:0]        key_next    [DEPTH];
    logic [HANDLE_W-1:0]  handle_next [DEPTH];
    logic [KW-1:0]        up_key      [DEPTH];
    logic [HANDLE_W-1:0]  up_handle   [DEPTH];
    logic [KW-1:0]        dn_key      [DEPTH];
    logic [HANDLE_W-1:0]  dn_handle   [DEPTH];

    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;

    logic [DEPTH-1:0]     lt;
    logic [DEPTH-1:0]     eq;
    logic [DEPTH-1:0]     lt_ext;
    logic                 found;
    logic                 full;
    logic                 ins_ok;
    logic                 del_ok;
    status_t              status;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    status_t              out_status_reg;
    logic [COUNT_OUT_W-1:0] out_count_reg;
    logic [CW+COUNT_OUT_W-1:0] count_ext;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg      <= func_t'(s_tuser);
            key_in_reg    <= s_tdata[KW-1:0];
            handle_in_reg <= s_tdata[KEY_IN_W +: HANDLE_W];
        end
    end

    // cell i sees whether the cell below it still holds a smaller key
    assign lt_ext = {lt[DEPTH-2:0], 1'b1};

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic vld;
        assign vld         = CW'(i) < count_reg;
        assign lt[i]       = vld && (key_reg[i] < key_in_reg);
        assign eq[i]       = vld && (key_reg[i] == key_in_reg);

        if (i == 0)
        begin : g_first
            assign up_key[i]    = key_in_reg;
            assign up_handle[i] = handle_in_reg;
        end
        else
        begin : g_mid
            assign up_key[i]    = key_reg[i-1];
            assign up_handle[i] = handle_reg[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign dn_key[i]    = key_reg[i];
            assign dn_handle[i] = handle_reg[i];
        end
        else
        begin : g_low
            assign dn_key[i]    = key_reg[i+1];
            assign dn_handle[i] = handle_reg[i+1];
        end

        // cells at or past the slot move up on insert, down on delete
        always_comb
        begin
            key_next[i]    = key_reg[i];
            handle_next[i] = handle_reg[i];
            if (ins_ok && !lt[i])
            begin
                if (lt_ext[i])
                begin
                    key_next[i]    = key_in_reg;
                    handle_next[i] = handle_in_reg;
                end
                else
                begin
                    key_next[i]    = up_key[i];
                    handle_next[i] = up_handle[i];
                end
            end
            else if (del_ok && !lt[i])
            begin
                key_next[i]    = dn_key[i];
                handle_next[i] = dn_handle[i];
            end
        end

        always_ff @(posedge clk)
        begin
            key_reg[i]    <= key_next[i];
            handle_reg[i] <= handle_next[i];
        end
    end

    assign found  = |eq;
    assign full   = count_reg == CW'(DEPTH);
    assign ins_ok = cmd.exec && (func_reg == FN_INSERT) && !found && !full;
    assign del_ok = cmd.exec && (func_reg == FN_DELETE) && found;

    always_comb
    begin
        case (func_reg)
            FN_INSERT: status = found ? ST_DUP : (full ? ST_FULL : ST_DONE);
            FN_DELETE: status = found ? ST_DONE : ST_NOTFOUND;
            default:   status = ST_DONE;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (ins_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (del_ok)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    assign count_ext = {{COUNT_OUT_W{1'b0}}, count_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            out_status_reg <= status;
            out_count_reg  <= count_ext[COUNT_OUT_W-1:0];
        end
    end

    assign sts.out_busy = out_valid_reg && !m_tready;
    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = {{(M_TDATA_W-STATUS_W-COUNT_OUT_W){1'b0}},
                           out_count_reg, out_status_reg};

endmodule

>>> rtl/sorted_key_table_insert_delete.sv
// top level of the sorted key table with insert and delete
//
// channel   dir  tdata (lowest bit up)                     tuser
// s_*       in   key[47:0], handle[63:48]                  func (0 insert, 1 delete)
// m_*       out  status[1:0], entry_count[8:2], zero pad   -
//
// each item is first captured, then executed: every cell
// compares its key against the item and the whole row shifts at once
// the next item is taken the cycle after the result is written to the
// output register; a stalled output only holds the execute step
// reset clears the entry count and the result valid; the cells hold no
// reset value, entries at or above the count are never looked at
module sorted_key_table_insert_delete #(
    parameter int DEPTH     = 64,
    parameter int KEY_CHARS = 6
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    // operation items
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [skt_pkg::S_TDATA_W-1:0]  s_tdata,   // key[47:0], handle[63:48]
    input  logic                           s_tuser,   // func
    // result items
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [skt_pkg::M_TDATA_W-1:0]  m_tdata    // status[1:0], entry_count[8:2]
);
    import skt_pkg::*;

    // key bits that take part: the narrower of the character count and the port
    localparam int KEY_W = (8 * KEY_CHARS < KEY_IN_W) ? 8 * KEY_CHARS : KEY_IN_W;

    ctrl_cmd_t cmd;
    dp_sts_t   sts;

    // sequencing: accept, then execute when the result slot is free
    skt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // compare-and-shift row plus result register
    skt_datapath #(
        .DEPTH (DEPTH),
        .KW    (KEY_W)
    ) u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

>>> rtl/skt_checker.sv
// port-level checks for the sorted key table, bound to the top level
module skt_checker #(
    parameter int DEPTH = 64
)
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [skt_pkg::M_TDATA_W-1:0]  m_tdata
);
    import skt_pkg::*;

    localparam logic [COUNT_OUT_W-1:0] FULL_COUNT = COUNT_OUT_W'(DEPTH);

    // one item in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while previous one still executing");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed under stall");

    // a table-full report carries the full count
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[STATUS_W-1:0] == ST_FULL)
        |-> m_tdata[STATUS_W +: COUNT_OUT_W] == FULL_COUNT)
        else $error("table full reported with wrong entry count");

    // a new result follows the execute cycle, when input is not taken
    a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without an execute cycle");

    // padding above the count stays zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[M_TDATA_W-1:STATUS_W+COUNT_OUT_W] == '0)
        else $error("result padding not zero");

endmodule

bind sorted_key_table_insert_delete skt_checker #(.DEPTH(DEPTH)) u_skt_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
